[rtl/b64sc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

   localparam int unsigned BatchMax = 4;
   localparam int unsigned CntW     = $clog2(BatchMax + 1);

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [1:0] phase;
      logic [5:0] carry;
      logic       stopped;
   } grp_state_type;

   typedef struct packed {
      logic [CntW-1:0]           cnt;
      logic [BatchMax-1:0][7:0]  data;
      logic                      dv;    // data flag of entry 0
      logic                      last;  // batch closes the message
   } batch_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] sextet;
   } sextet_type;

   function automatic logic [7:0] enc_char(input logic [5:0] s);
      logic [7:0] w;
      w = {2'b00, s};
      if (s < 6'd26)      enc_char = 8'(w + 8'h41);
      else if (s < 6'd52) enc_char = 8'(w + 8'h47);
      else if (s < 6'd62) enc_char = 8'(w - 8'h04);
      else if (s == 6'd62) enc_char = 8'h2B;
      else                enc_char = 8'h2F;
   endfunction

   function automatic sextet_type dec_char(input logic [7:0] ch);
      sextet_type r;
      r.ok     = 1'b1;
      r.sextet = 6'd0;
      if (ch >= 8'h41 && ch <= 8'h5A)      r.sextet = 6'(ch - 8'h41);
      else if (ch >= 8'h61 && ch <= 8'h7A) r.sextet = 6'(ch - 8'h47);
      else if (ch >= 8'h30 && ch <= 8'h39) r.sextet = 6'(ch + 8'h04);
      else if (ch == 8'h2B)                r.sextet = 6'd62;
      else if (ch == 8'h2F)                r.sextet = 6'd63;
      else                                 r.ok     = 1'b0;
      return r;
   endfunction

endpackage

[rtl/b64sc_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_req_if
// Input channel of the codec: one byte or character per item.
// ----------------------------------------------------------------------------
interface b64sc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/b64sc_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_rsp_if
// Result channel of the codec: one character or byte per item.
// ----------------------------------------------------------------------------
interface b64sc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       out_last;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   output ready);
endinterface

[rtl/b64sc_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64sc_step
// Combinational group step: maps one input item and the group state to the
// batch of results it completes and the next group state.
// ----------------------------------------------------------------------------
module b64sc_step
   import b64sc_pkg::*;
(
   input  logic          mode,
   input  logic [7:0]    in_byte,
   input  logic          in_last,
   input  grp_state_type st,
   output grp_state_type st_nxt,
   output batch_type     batch
);

   logic [1:0] ph;
   sextet_type dc;

   always_comb begin
      ph     = st.phase;
      dc     = dec_char(in_byte);
      st_nxt = st;
      batch  = '0;
      batch.dv   = 1'b1;
      batch.last = in_last;

      if (mode == MODE_ENCODE) begin
         if (ph == 2'd3) begin
            ph = 2'd0;
         end
         st_nxt.stopped = 1'b0;
         case (ph)
            2'd0: begin
               batch.data[0] = enc_char(in_byte[7:2]);
               if (in_last) begin
                  batch.data[1] = enc_char({in_byte[1:0], 4'b0000});
                  batch.data[2] = PAD_CHAR;
                  batch.data[3] = PAD_CHAR;
                  batch.cnt     = CntW'(4);
               end else begin
                  batch.cnt     = CntW'(1);
               end
               st_nxt.carry = {in_byte[1:0], 4'b0000};
               st_nxt.phase = 2'd1;
            end
            2'd1: begin
               batch.data[0] = enc_char(st.carry | {2'b00, in_byte[7:4]});
               if (in_last) begin
                  batch.data[1] = enc_char({in_byte[3:0], 2'b00});
                  batch.data[2] = PAD_CHAR;
                  batch.cnt     = CntW'(3);
               end else begin
                  batch.cnt     = CntW'(1);
               end
               st_nxt.carry = {in_byte[3:0], 2'b00};
               st_nxt.phase = 2'd2;
            end
            default: begin
               batch.data[0] = enc_char(st.carry | {4'b0000, in_byte[7:6]});
               batch.data[1] = enc_char(in_byte[5:0]);
               batch.cnt     = CntW'(2);
               st_nxt.carry  = '0;
               st_nxt.phase  = 2'd0;
            end
         endcase
      end else begin
         if (!st.stopped) begin
            if (in_byte == PAD_CHAR && ph[1]) begin
               st_nxt.stopped = 1'b1;
            end else if (dc.ok) begin
               case (ph)
                  2'd0: begin
                     st_nxt.carry = dc.sextet;
                     st_nxt.phase = 2'd1;
                  end
                  2'd1: begin
                     batch.data[0] = {st.carry, dc.sextet[5:4]};
                     batch.cnt     = CntW'(1);
                     st_nxt.carry  = {2'b00, dc.sextet[3:0]};
                     st_nxt.phase  = 2'd2;
                  end
                  2'd2: begin
                     batch.data[0] = {st.carry[3:0], dc.sextet[5:2]};
                     batch.cnt     = CntW'(1);
                     st_nxt.carry  = {4'b0000, dc.sextet[1:0]};
                     st_nxt.phase  = 2'd3;
                  end
                  default: begin
                     batch.data[0] = {st.carry[1:0], dc.sextet};
                     batch.cnt     = CntW'(1);
                     st_nxt.carry  = '0;
                     st_nxt.phase  = 2'd0;
                  end
               endcase
            end
         end
         // a closing item with no byte still gives one empty result
         if (in_last && batch.cnt == '0) begin
            batch.cnt = CntW'(1);
            batch.dv  = 1'b0;
         end
      end

      if (in_last) begin
         st_nxt = '0;
      end
   end

endmodule

[rtl/base64_stream_codec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, standard alphabet, mode selected by CSR.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_chan  in    valid/ready    in_byte[7:0], in_last
//  rsp_chan  out   valid/ready    out_byte[7:0], out_valid, out_last
//  csr_*     in    csr_wr_en      csr_wr_data = mode (0 encode, 1 decode)
//
//  An item is registered, then one pass of logic turns it into up to four
//  results held in a result buffer that drains one result per cycle while
//  the result port is ready. Decode sustains one item per cycle while the
//  result port is ready; encode is bound by the result port at four
//  characters per three bytes (plus up to three on the last byte). Reset is
//  synchronous and clears mode, group state and both stages; a stalled
//  result port holds the buffer and then the input register.
// ----------------------------------------------------------------------------
module base64_stream_codec
   import b64sc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   b64sc_req_if.sink    req_chan,
   b64sc_rsp_if.source  rsp_chan,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic          mode_ff;
   grp_state_type st_ff, st_nxt;

   logic          item_v_ff, item_v_in;
   logic [7:0]    item_byte_ff;
   logic          item_last_ff;

   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [BatchMax-1:0][7:0] data_ff, data_in;
   logic                     dv_ff, dv_in;
   logic                     last_ff, last_in;

   batch_type batch;
   logic      pop, load, take;

   b64sc_step u_step (
      .mode    (mode_ff),
      .in_byte (item_byte_ff),
      .in_last (item_last_ff),
      .st      (st_ff),
      .st_nxt  (st_nxt),
      .batch   (batch)
   );

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign load = item_v_ff && (cnt_ff == '0 || (cnt_ff == CntW'(1) && rsp_chan.ready));
   assign take = req_chan.valid && req_chan.ready;

   assign req_chan.ready     = !item_v_ff || load;
   assign rsp_chan.valid     = (cnt_ff != '0);
   assign rsp_chan.out_byte  = data_ff[0];
   assign rsp_chan.out_valid = dv_ff;
   assign rsp_chan.out_last  = last_ff && (cnt_ff == CntW'(1));

   always_comb begin
      item_v_in = take || (item_v_ff && !load);
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      dv_in     = dv_ff;
      last_in   = last_ff;
      if (load) begin
         cnt_in  = batch.cnt;
         data_in = batch.data;
         dv_in   = batch.dv;
         last_in = batch.last;
      end else if (pop) begin
         // advance the buffer by one entry
         cnt_in  = CntW'(cnt_ff - CntW'(1));
         for (int i = 0; i < BatchMax - 1; i++) begin
            data_in[i] = data_ff[i+1];
         end
         dv_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ENCODE;
         st_ff     <= '0;
         item_v_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         item_v_ff <= item_v_in;
         cnt_ff    <= cnt_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
            st_ff   <= '0;
         end else if (load) begin
            st_ff   <= st_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_byte_ff <= req_chan.in_byte;
         item_last_ff <= req_chan.in_last;
      end
      data_ff <= data_in;
      dv_ff   <= dv_in;
      last_ff <= last_in;
   end

   // empty results only close a message
   a_empty_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.out_valid |-> rsp_chan.out_last)
      else $error("empty result not marked last");

   // every encoded result carries a character
   a_enc_all_data : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && mode_ff == MODE_ENCODE |-> rsp_chan.out_valid)
      else $error("empty result in encode mode");

   a_cnt_range : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(BatchMax))
      else $error("result buffer count out of range");

   // encode never reaches the fourth group position
   a_enc_phase : assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ENCODE |-> st_ff.phase != 2'd3)
      else $error("encode group phase out of range");

endmodule
